// ===== design/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared codes and types for the double-ended queue with search.
// ----------------------------------------------------------------------------
package deq_pkg;

	// payload widths fixed by the interface
	localparam int unsigned DATA_W = 32;
	localparam int unsigned FUNC_W = 3;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned POS_W  = 6;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_PUSH_HEAD = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_TAIL = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_HEAD  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_TAIL  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SEARCH    = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DUMP      = 3'd5;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK
	} state_t;

endpackage

// ===== design/deq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/double_ended_queue_with_search_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_core
// Bounded deque of signed 32-bit values held in a ring RAM, with push and pop
// at both ends, first-match search from the head and an in-order dump.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   req     | req_valid req_ready func operand          | in
//   rsp     | rsp_valid rsp_ready status element        | out
//           | position last now_empty                   |
//
// Push, pop, unused codes and any operation on an empty queue: accept,
// then execute into the output register. Search compares entries from
// the head to the first hit or the tail; dump gives one response per entry.
// One RAM read per cycle sets the walk rate while responses are taken.
// Reset clears head, count and the response valid flag; RAM contents are
// undefined and never read outside the count.
// A stalled response holds the sequencer; a new request is accepted while
// the last response of the previous one still waits.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_core #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [deq_pkg::FUNC_W-1:0]       func,
	input  logic signed [deq_pkg::DATA_W-1:0] operand,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [deq_pkg::STAT_W-1:0]       status,
	output logic signed [deq_pkg::DATA_W-1:0] element,
	output logic [deq_pkg::POS_W-1:0]        position,
	output logic                             last,
	output logic                             now_empty
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = AW + 1;

	deq_pkg::state_t state_q, state_d;

	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [deq_pkg::FUNC_W-1:0] func_q;
	logic [deq_pkg::DATA_W-1:0] operand_q;

	logic                       out_valid_q;
	logic [deq_pkg::STAT_W-1:0] status_q, st_d;
	logic [deq_pkg::DATA_W-1:0] element_q, elem_d;
	logic [deq_pkg::POS_W-1:0]  position_q, pos_d;
	logic                       last_q, last_d;
	logic                       now_empty_q, empty_d;
	logic                       out_load;
	logic                       out_free;

	logic                       ram_we, ram_re;
	logic [AW-1:0]              ram_waddr, ram_raddr;
	logic [deq_pkg::DATA_W-1:0] ram_rdata;

	logic [AW-1:0] head_next, head_prev, ptr_next, tail_addr;
	logic [SW-1:0] tail_sum;
	logic          entry_last, entry_match, walk_op, is_empty;

	// ring pointer arithmetic
	assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign ptr_next  = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
		: AW'(tail_sum);

	assign is_empty    = (count_q == '0);
	assign walk_op     = (func_q == deq_pkg::FN_SEARCH) || (func_q == deq_pkg::FN_DUMP);
	assign entry_last  = ((SW'(idx_q) + 1'b1) == SW'(count_q));
	assign entry_match = (ram_rdata == operand_q);
	assign out_free    = !out_valid_q || rsp_ready;

	// entry store
	deq_ram #(
		.WIDTH (deq_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (operand_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath control
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		out_load  = 1'b0;
		st_d      = deq_pkg::ST_OK;
		elem_d    = '0;
		pos_d     = '0;
		last_d    = 1'b1;
		head_d    = head_q;
		count_d   = count_q;
		ram_we    = 1'b0;
		ram_waddr = tail_addr;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		ptr_d     = ptr_q;
		idx_d     = idx_q;
		unique case (state_q)
			deq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = deq_pkg::S_EXEC;
				end
			end
			deq_pkg::S_EXEC: begin
				priority if (walk_op && !is_empty) begin
					// start walk at the head entry
					ram_re    = 1'b1;
					ram_raddr = head_q;
					ptr_d     = head_next;
					idx_d     = '0;
					state_d   = deq_pkg::S_WALK;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = deq_pkg::S_IDLE;
					unique case (func_q)
						deq_pkg::FN_PUSH_HEAD, deq_pkg::FN_PUSH_TAIL: begin
							if (count_q == CW'(DEPTH)) begin
								st_d = deq_pkg::ST_FULL;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + 1'b1;
								if (func_q == deq_pkg::FN_PUSH_HEAD) begin
									head_d    = head_prev;
									ram_waddr = head_prev;
								end
							end
						end
						deq_pkg::FN_POP_HEAD, deq_pkg::FN_POP_TAIL: begin
							if (is_empty) begin
								st_d = deq_pkg::ST_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
								if (func_q == deq_pkg::FN_POP_HEAD) begin
									head_d = head_next;
								end
							end
						end
						deq_pkg::FN_SEARCH, deq_pkg::FN_DUMP: begin
							st_d = deq_pkg::ST_EMPTY;
						end
						default: begin
							st_d = deq_pkg::ST_OK;
						end
					endcase
				end else begin
					state_d = deq_pkg::S_EXEC;
				end
			end
			deq_pkg::S_WALK: begin
				if (func_q == deq_pkg::FN_SEARCH) begin
					// compare one entry per cycle, report on hit or at the tail
					if (entry_match || entry_last) begin
						if (out_free) begin
							out_load = 1'b1;
							st_d     = entry_match ? deq_pkg::ST_OK : deq_pkg::ST_MISS;
							elem_d   = entry_match ? ram_rdata : '0;
							pos_d    = entry_match ? deq_pkg::POS_W'(idx_q) : '0;
							state_d  = deq_pkg::S_IDLE;
						end
					end else begin
						ram_re    = 1'b1;
						ram_raddr = ptr_q;
						ptr_d     = ptr_next;
						idx_d     = idx_q + 1'b1;
					end
				end else if (out_free) begin
					// dump one entry per response
					out_load = 1'b1;
					elem_d   = ram_rdata;
					pos_d    = deq_pkg::POS_W'(idx_q);
					last_d   = entry_last;
					if (entry_last) begin
						state_d = deq_pkg::S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = ptr_q;
						ptr_d     = ptr_next;
						idx_d     = idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = deq_pkg::S_IDLE;
			end
		endcase
		empty_d = (count_d == '0);
	end

	// queue control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// walk pointers and captured request
	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		idx_q <= idx_d;
		if (req_valid && req_ready) begin
			func_q    <= func;
			operand_q <= operand;
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q    <= st_d;
			element_q   <= elem_d;
			position_q  <= pos_d;
			last_q      <= last_d;
			now_empty_q <= empty_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign position  = position_q;
	assign last      = last_q;
	assign now_empty = now_empty_q;

	// count never passes capacity, head stays inside the ring
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CW'(DEPTH)))
		else $error("entry count beyond capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= AW'(DEPTH - 1)))
		else $error("head outside ring");

	// a walk only runs over a non-empty queue and inside the count
	a_walk_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == deq_pkg::S_WALK) |-> (!is_empty && (SW'(idx_q) < SW'(count_q))))
		else $error("walk index outside queue");

	// writes and reads never share a cycle, so no forwarding is needed
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (!ram_re && state_q == deq_pkg::S_EXEC))
		else $error("store write outside execute or with a read");

	// a new response is only loaded when the output register frees up
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !out_load)
		else $error("pending response overwritten");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended queue with search. Requests are
// driven through the req channel with random gaps. A scoreboard keeps its own
// ring, head and count, and predicts every response of each accepted request.
// It then compares the rsp channel field by field, in order. The directed part
// covers the empty, full, miss and unused-code cases. The random part runs in
// fill, drain and mixed phases so that the queue often reaches both ends.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned DEPTH           = 16;
	localparam int unsigned RANDOM_ITEMS    = 343;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned HOLD_OFF_AFTER  = 80;
	localparam int unsigned DRAIN_CYCLES    = 40;
	localparam int unsigned MAX_REPORTS     = 10;

	// codes the package leaves unnamed
	localparam logic [deq_pkg::FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [deq_pkg::FUNC_W-1:0] FN_SPARE_B = 3'd7;

	typedef enum int unsigned {
		MIX_FILL,
		MIX_DRAIN,
		MIX_BALANCED
	} mix_t;

	typedef struct {
		logic [deq_pkg::STAT_W-1:0]        status;
		logic signed [deq_pkg::DATA_W-1:0] element;
		logic [deq_pkg::POS_W-1:0]         position;
		logic                              last;
		logic                              now_empty;
	} deq_result_t;

	// predicts responses and checks them in order
	class deq_scoreboard;
		logic [deq_pkg::DATA_W-1:0] ring [DEPTH];
		int unsigned                head;
		int unsigned                count;
		deq_result_t                expected_q [$];
		int unsigned                errors;

		function void clear();
			foreach (ring[i]) ring[i] = '0;
			head   = 0;
			count  = 0;
			errors = 0;
			expected_q.delete();
		endfunction

		function int unsigned slot(int unsigned offset);
			return (head + offset) % DEPTH;
		endfunction

		function void add_result(logic [deq_pkg::STAT_W-1:0] st,
				logic [deq_pkg::DATA_W-1:0] el, int unsigned pos, logic lst);
			deq_result_t r;
			r.status    = st;
			r.element   = el;
			r.position  = deq_pkg::POS_W'(pos);
			r.last      = lst;
			r.now_empty = (count == 0);
			expected_q.push_back(r);
		endfunction

		function void note_request(logic [deq_pkg::FUNC_W-1:0] fn,
				logic [deq_pkg::DATA_W-1:0] op);
			int unsigned i;
			bit          hit;
			case (fn)
				deq_pkg::FN_PUSH_HEAD, deq_pkg::FN_PUSH_TAIL: begin
					if (count >= DEPTH) begin
						add_result(deq_pkg::ST_FULL, '0, 0, 1'b1);
					end else begin
						if (fn == deq_pkg::FN_PUSH_HEAD) begin
							head       = (head + DEPTH - 1) % DEPTH;
							ring[head] = op;
						end else begin
							ring[slot(count)] = op;
						end
						count++;
						add_result(deq_pkg::ST_OK, '0, 0, 1'b1);
					end
				end
				deq_pkg::FN_POP_HEAD, deq_pkg::FN_POP_TAIL: begin
					if (count == 0) begin
						add_result(deq_pkg::ST_EMPTY, '0, 0, 1'b1);
					end else begin
						if (fn == deq_pkg::FN_POP_HEAD) head = slot(1);
						count--;
						add_result(deq_pkg::ST_OK, '0, 0, 1'b1);
					end
				end
				deq_pkg::FN_SEARCH: begin
					if (count == 0) begin
						add_result(deq_pkg::ST_EMPTY, '0, 0, 1'b1);
					end else begin
						hit = 1'b0;
						for (i = 0; i < count && !hit; i++) begin
							if (ring[slot(i)] == op) begin
								add_result(deq_pkg::ST_OK, ring[slot(i)], i, 1'b1);
								hit = 1'b1;
							end
						end
						if (!hit) add_result(deq_pkg::ST_MISS, '0, 0, 1'b1);
					end
				end
				deq_pkg::FN_DUMP: begin
					if (count == 0) begin
						add_result(deq_pkg::ST_EMPTY, '0, 0, 1'b1);
					end else begin
						for (i = 0; i < count; i++)
							add_result(deq_pkg::ST_OK, ring[slot(i)], i, (i + 1 == count));
					end
				end
				default: begin
					add_result(deq_pkg::ST_OK, '0, 0, 1'b1);
				end
			endcase
		endfunction

		function void check_response(deq_result_t got);
			deq_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected: st %0d el %0d pos %0d last %0b empty %0b",
						got.status, got.element, got.position, got.last, got.now_empty);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.element !== want.element ||
					got.position !== want.position || got.last !== want.last ||
					got.now_empty !== want.now_empty) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("response mismatch at %0t", $realtime);
					$display("  expected: st %0d el %0d pos %0d last %0b empty %0b",
						want.status, want.element, want.position, want.last, want.now_empty);
					$display("  actual:   st %0d el %0d pos %0d last %0b empty %0b",
						got.status, got.element, got.position, got.last, got.now_empty);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              req_valid;
	logic                              req_ready;
	logic [deq_pkg::FUNC_W-1:0]        func;
	logic signed [deq_pkg::DATA_W-1:0] operand;
	logic                              rsp_valid;
	logic                              rsp_ready;
	logic [deq_pkg::STAT_W-1:0]        status;
	logic signed [deq_pkg::DATA_W-1:0] element;
	logic [deq_pkg::POS_W-1:0]         position;
	logic                              last;
	logic                              now_empty;

	deq_scoreboard sb;
	deq_result_t   observed;
	int unsigned   responses_taken = 0;
	bit            tight = 1'b0;

	double_ended_queue_with_search_core #(
		.DEPTH(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.func      (func),
		.operand   (operand),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.element   (element),
		.position  (position),
		.last      (last),
		.now_empty (now_empty)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// operands: extremes, a small pool for duplicates, full random words
	function automatic logic [deq_pkg::DATA_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h8000_0000;
		if (r == 1) return 32'h7fff_ffff;
		if (r < 5) return deq_pkg::DATA_W'($signed($urandom_range(0, 3)) - 1);
		return $urandom();
	endfunction

	// search targets are mostly values the queue holds right now
	function automatic logic [deq_pkg::DATA_W-1:0] pick_search_value();
		if (sb.count > 0 && $urandom_range(0, 99) < 60)
			return sb.ring[sb.slot($urandom_range(0, sb.count - 1))];
		return pick_value();
	endfunction

	function automatic logic [deq_pkg::FUNC_W-1:0] pick_func(mix_t mode);
		int unsigned r;
		int unsigned push_pct;
		int unsigned pop_pct;
		r = $urandom_range(0, 99);
		case (mode)
			MIX_FILL: begin
				push_pct = 65;
				pop_pct  = 10;
			end
			MIX_DRAIN: begin
				push_pct = 10;
				pop_pct  = 65;
			end
			default: begin
				push_pct = 35;
				pop_pct  = 35;
			end
		endcase
		if (r < 3) return ($urandom_range(0, 1) != 0) ? FN_SPARE_B : FN_SPARE_A;
		r = r - 3;
		if (r < push_pct)
			return ($urandom_range(0, 1) != 0) ? deq_pkg::FN_PUSH_TAIL : deq_pkg::FN_PUSH_HEAD;
		if (r < push_pct + pop_pct)
			return ($urandom_range(0, 1) != 0) ? deq_pkg::FN_POP_TAIL : deq_pkg::FN_POP_HEAD;
		if (r < push_pct + pop_pct + 13) return deq_pkg::FN_SEARCH;
		return deq_pkg::FN_DUMP;
	endfunction

	// offer one request and hold it until accepted
	task automatic send_item(logic [deq_pkg::FUNC_W-1:0] fn,
			logic [deq_pkg::DATA_W-1:0] op);
		int unsigned gap;
		req_valid <= 1'b1;
		func      <= fn;
		operand   <= op;
		do @(posedge clk); while (!req_ready);
		gap = tight ? 0 : gap_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// transaction monitor on both channels
	always @(posedge clk) begin
		if (req_valid && req_ready) sb.note_request(func, operand);
		if (rsp_valid && rsp_ready) begin
			observed.status    = status;
			observed.element   = element;
			observed.position  = position;
			observed.last      = last;
			observed.now_empty = now_empty;
			sb.check_response(observed);
			responses_taken++;
		end
	end

	// response side: random stalls plus one long hold-off to back up the block
	initial begin
		int unsigned on_len;
		int unsigned gap;
		bit          held_off;
		rsp_ready = 1'b0;
		held_off  = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held_off && responses_taken >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			on_len = $urandom_range(1, 24);
			repeat (on_len) @(posedge clk);
			gap = gap_len();
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// stimulus and end of test
	initial begin
		int unsigned                i;
		int unsigned                sent;
		int unsigned                len;
		mix_t                       mode;
		logic [deq_pkg::FUNC_W-1:0] fn;
		logic [deq_pkg::DATA_W-1:0] op;
		sb = new;
		sb.clear();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		func      = deq_pkg::FN_PUSH_HEAD;
		operand   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue cases and an unused code
		send_item(deq_pkg::FN_POP_HEAD, '0);
		send_item(deq_pkg::FN_SEARCH, '0);
		send_item(deq_pkg::FN_DUMP, '0);
		send_item(FN_SPARE_A, 32'hffff_ffff);

		// fill from both ends, extremes first
		for (i = 0; i < DEPTH; i++) begin
			case (i)
				0:       op = 32'h8000_0000;
				1:       op = 32'h7fff_ffff;
				2:       op = 32'h0000_0000;
				3:       op = 32'hffff_ffff;
				default: op = $urandom();
			endcase
			send_item((i % 2 != 0) ? deq_pkg::FN_PUSH_TAIL : deq_pkg::FN_PUSH_HEAD, op);
		end

		// full queue drops pushes at either end
		send_item(deq_pkg::FN_PUSH_HEAD, 32'h0000_1234);
		send_item(deq_pkg::FN_PUSH_TAIL, 32'h8765_4321);

		// hit, miss, full dump, then pop at both ends
		send_item(deq_pkg::FN_SEARCH, 32'h7fff_ffff);
		send_item(deq_pkg::FN_SEARCH, 32'h5555_5555);
		send_item(deq_pkg::FN_DUMP, '0);
		send_item(deq_pkg::FN_POP_HEAD, '0);
		send_item(deq_pkg::FN_POP_TAIL, '0);

		// random phases
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode  = mix_t'($urandom_range(0, 2));
			tight = ($urandom_range(0, 3) == 0);
			len   = $urandom_range(10, 40);
			if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
			repeat (len) begin
				fn = pick_func(mode);
				op = (fn == deq_pkg::FN_SEARCH) ? pick_search_value() : pick_value();
				send_item(fn, op);
				sent++;
			end
		end
		req_valid <= 1'b0;

		// let the last responses drain
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#96_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/deq_pkg.sv
design/deq_ram.sv
design/double_ended_queue_with_search_core.sv
dv/tb_top.sv
